[hw/rtl/tdh_pkg.sv]
// Shared types, widths, codes and reset values of the timestamp delta histogram.
package tdh_pkg;

    // Default sizes of the two memories.
    localparam int unsigned MAX_BINS_DEF    = 64;
    localparam int unsigned STORE_DEPTH_DEF = 8192;

    // Item field widths.
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned TS_W      = 63;
    localparam int unsigned IDX_W     = 13;
    localparam int unsigned CALL_W    = 32;
    localparam int unsigned CNT_OUT_W = 14;
    localparam int unsigned VAL_W     = 63;

    // Register widths.
    localparam int unsigned MIN_W  = 32;
    localparam int unsigned BSZ_W  = 32;
    localparam int unsigned NBIN_W = 7;
    localparam int unsigned END_W  = 40;

    // Internal datapath widths.
    localparam int unsigned REL_W     = 64;
    localparam int unsigned BIN_CNT_W = 32;

    // Configuration port.
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 64;

    // Divider: two quotient bits per cycle over a 64-bit dividend.
    localparam int unsigned DIV_STEPS = REL_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Register reset values.
    localparam logic [MIN_W-1:0]  MIN_INC_RST  = 32'd1;
    localparam logic [BSZ_W-1:0]  BIN_SIZE_RST = 32'd1;
    localparam logic [NBIN_W-1:0] BINS_RST     = 7'd64;
    localparam logic [END_W-1:0]  END_RST      = 40'd2000000000;

    // Largest value a captured increase can report.
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START      = 2'd0,
        CMD_SAMPLE     = 2'd1,
        CMD_READ_BIN   = 2'd2,
        CMD_READ_STORE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_MIN_INCREASE = 2'd0,
        REG_BIN_SIZE     = 2'd1,
        REG_BINS_IN_USE  = 2'd2,
        REG_END_TICKS    = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REL,
        ST_CLASS,
        ST_CMP,
        ST_DIV,
        ST_CLAMP,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_READ,
        ST_READ_DATA,
        ST_RESP
    } t_state;

endpackage

[hw/rtl/tdh_if.sv]
// Valid/ready channel interfaces for command items and result items.
interface tdh_in_if;
    logic                         valid;
    logic                         ready;
    logic [tdh_pkg::CMD_W-1:0]    cmd;
    logic [tdh_pkg::TS_W-1:0]     timestamp;
    logic [tdh_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, cmd, timestamp, read_index, input ready);
    modport sink   (input valid, cmd, timestamp, read_index, output ready);
endinterface

interface tdh_out_if;
    logic                           valid;
    logic                           ready;
    logic                           done_res;
    logic [tdh_pkg::CALL_W-1:0]     call_total;
    logic [tdh_pkg::CNT_OUT_W-1:0]  captured_total;
    logic [tdh_pkg::VAL_W-1:0]      read_value;

    modport source (output valid, done_res, call_total, captured_total, read_value,
                    input ready);
    modport sink   (input valid, done_res, call_total, captured_total, read_value,
                    output ready);
endinterface

[hw/rtl/timestamp_delta_histogram.sv]
// Top level of the timestamp delta histogram: control sequencer, run state and memories.
//
//   Channel   Dir   Handshake            Payload
//   i_in      in    valid/ready          cmd, timestamp, read_index
//   o_out     out   valid/ready          done_res, call_total, captured_total, read_value
//   APB       in    psel/penable/pready  paddr, pwdata, pwrite; prdata back
//
// One item is worked on at a time. A sample with a positive increase at or
// above the minimum waits on the divider, which retires two quotient bits
// per cycle over a 64-bit dividend. A sample after the end limit goes
// straight to the result, and a start item runs the pass that writes zero
// to each bin entry. After reset the same clearing pass runs before the
// first item is accepted. The output register lets the sequencer finish an
// item while the previous result still waits; it stalls only when that
// register is still full at the moment the next result is ready.
module timestamp_delta_histogram #(
    parameter int unsigned MAX_BINS    = tdh_pkg::MAX_BINS_DEF,
    parameter int unsigned STORE_DEPTH = tdh_pkg::STORE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tdh_in_if.sink                      i_in,
    tdh_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tdh_pkg::APB_AW-1:0]  paddr,
    input  logic [tdh_pkg::APB_DW-1:0]  pwdata,
    output logic [tdh_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tdh_pkg::*;

    localparam int unsigned BIN_AW = $clog2(MAX_BINS);
    localparam int unsigned NB_W   = $clog2(MAX_BINS + 1);
    localparam int unsigned ST_AW  = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Registers sit on 8-byte boundaries, so the
    // register index is the address above the low three bits.
    // ------------------------------------------------------------------
    logic [MIN_W-1:0]  r_min_increase;
    logic [BSZ_W-1:0]  r_bin_size;
    logic [NBIN_W-1:0] r_bins_in_use;
    logic [END_W-1:0]  r_end_ticks;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_increase <= MIN_INC_RST;
            r_bin_size     <= BIN_SIZE_RST;
            r_bins_in_use  <= BINS_RST;
            r_end_ticks    <= END_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MIN_INCREASE: r_min_increase <= pwdata[MIN_W-1:0];
                REG_BIN_SIZE:     r_bin_size     <= pwdata[BSZ_W-1:0];
                REG_BINS_IN_USE:  r_bins_in_use  <= pwdata[NBIN_W-1:0];
                REG_END_TICKS:    r_end_ticks    <= pwdata[END_W-1:0];
                default:          r_end_ticks    <= r_end_ticks;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MIN_INCREASE: prdata = {(APB_DW-MIN_W)'(0), r_min_increase};
            REG_BIN_SIZE:     prdata = {(APB_DW-BSZ_W)'(0), r_bin_size};
            REG_BINS_IN_USE:  prdata = {(APB_DW-NBIN_W)'(0), r_bins_in_use};
            REG_END_TICKS:    prdata = {(APB_DW-END_W)'(0), r_end_ticks};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state, the accepted item and the run state.
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    t_cmd             r_cmd;
    logic [TS_W-1:0]  r_ts;
    logic [IDX_W-1:0] r_ri;

    logic [TS_W-1:0]   r_ref;
    logic [REL_W-1:0]  r_last;
    logic [REL_W-1:0]  r_rel;
    logic [REL_W-1:0]  r_diff;
    logic [CALL_W-1:0] r_calls;
    logic [CNT_W-1:0]  r_captured;
    logic              r_finished;
    logic [BIN_AW-1:0] r_bin_idx;
    logic [BIN_AW-1:0] r_clr_addr;
    logic              r_after_start;
    logic              r_rd_ok;
    logic [VAL_W-1:0]  r_rd_val;

    logic                 r_out_valid;
    logic                 r_out_done;
    logic [CALL_W-1:0]    r_out_calls;
    logic [CNT_OUT_W-1:0] r_out_captured;
    logic [VAL_W-1:0]     r_out_value;

    // Control strobes.
    logic in_ready;
    logic accept;
    logic out_free;
    logic out_load;
    logic clr_last;

    // Memory ports.
    logic                 bin_we;
    logic [BIN_AW-1:0]    bin_waddr;
    logic [BIN_CNT_W-1:0] bin_wdata;
    logic [BIN_AW-1:0]    bin_raddr;
    logic [BIN_CNT_W-1:0] bin_rdata;
    logic                 st_we;
    logic [ST_AW-1:0]     st_waddr;
    logic [VAL_W-1:0]     st_wdata;
    logic [ST_AW-1:0]     st_raddr;
    logic [VAL_W-1:0]     st_rdata;

    // Divider.
    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [REL_W-1:0] div_quot;
    logic [BSZ_W-1:0] div_den;
    logic [REL_W-1:0] div_num;

    // ------------------------------------------------------------------
    // Datapath terms.
    // ------------------------------------------------------------------
    logic [REL_W-1:0]         rel_calc;
    logic [REL_W-1:0]         diff_calc;
    logic                     inc_neg;
    logic                     inc_pos;
    logic                     below_min;
    logic                     store_room;
    logic [NB_W+NBIN_W-1:0]   bins_ext;
    logic [NB_W+NBIN_W-1:0]   nb_wide;
    logic [NB_W-1:0]          nb;
    logic [NB_W-1:0]          nb_m1;
    logic [REL_W-1:0]         last_reg_q;
    logic [BIN_AW-1:0]        bin_sel;
    logic [ST_AW+IDX_W-1:0]   ri_st_ext;
    logic [CNT_W+IDX_W-1:0]   ri_cnt_ext;
    logic [CNT_W+IDX_W-1:0]   cap_ext;
    logic                     bin_rd_ok;
    logic                     st_rd_ok;

    // Relative time is the two's complement difference of 63-bit readings;
    // the sign of the increase comes from a signed compare, so it is exact.
    assign rel_calc  = {1'b0, r_ts} - {1'b0, r_ref};
    assign diff_calc = r_rel - r_last;
    assign inc_neg   = $signed(r_rel) < $signed(r_last);
    assign inc_pos   = !inc_neg && (r_rel != r_last);

    assign below_min = r_diff < {(REL_W-MIN_W)'(0), r_min_increase};
    assign div_num   = r_diff - {(REL_W-MIN_W)'(0), r_min_increase};
    assign div_den   = (r_bin_size == '0) ? BSZ_W'(1) : r_bin_size;

    // Effective bin count, held to the range three to MAX_BINS.
    always_comb begin
        bins_ext = {NB_W'(0), r_bins_in_use};
        if (bins_ext > (NB_W+NBIN_W)'(MAX_BINS)) begin
            nb_wide = (NB_W+NBIN_W)'(MAX_BINS);
        end else if (bins_ext < (NB_W+NBIN_W)'(3)) begin
            nb_wide = (NB_W+NBIN_W)'(3);
        end else begin
            nb_wide = bins_ext;
        end
        nb = nb_wide[NB_W-1:0];
    end

    // A quotient past the regular bins lands in the last bin in use.
    assign nb_m1      = nb - NB_W'(1);
    assign last_reg_q = {(REL_W-NB_W)'(0), nb} - REL_W'(2);
    assign bin_sel    = (div_quot >= last_reg_q) ? nb_m1[BIN_AW-1:0]
                                                 : div_quot[BIN_AW-1:0] + BIN_AW'(2);

    assign store_room = r_captured < CNT_W'(STORE_DEPTH);

    assign ri_st_ext  = {ST_AW'(0), r_ri};
    assign ri_cnt_ext = {CNT_W'(0), r_ri};
    assign cap_ext    = {IDX_W'(0), r_captured};
    assign bin_rd_ok  = r_ri < IDX_W'(MAX_BINS);
    // The fill count bounds store reads, so entries never written are not seen.
    assign st_rd_ok   = ri_cnt_ext < cap_ext;

    assign clr_last = r_clr_addr == BIN_AW'(MAX_BINS - 1);

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = r_after_start ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_in.cmd)) inside
                        CMD_START:  n_state = ST_CLEAR;
                        CMD_SAMPLE: n_state = r_finished ? ST_RESP : ST_REL;
                        CMD_READ_BIN, CMD_READ_STORE: n_state = ST_READ;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_REL:   n_state = ST_CLASS;
            ST_CLASS: begin
                if (inc_neg) begin
                    n_state = ST_BUMP_RD;
                end else if (inc_pos) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_CMP:       n_state = below_min ? ST_BUMP_RD : ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP:     n_state = ST_BUMP_RD;
            ST_BUMP_RD:   n_state = ST_BUMP_WR;
            ST_BUMP_WR:   n_state = ST_RESP;
            ST_READ:      n_state = ST_READ_DATA;
            ST_READ_DATA: n_state = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: handshakes, memory ports and divider start.
    // ------------------------------------------------------------------
    always_comb begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        bin_we    = 1'b0;
        bin_waddr = r_bin_idx;
        bin_wdata = (bin_rdata == '1) ? bin_rdata : bin_rdata + BIN_CNT_W'(1);
        bin_raddr = r_bin_idx;
        st_we     = 1'b0;
        st_waddr  = r_captured[ST_AW-1:0];
        st_wdata  = r_diff[REL_W-1] ? VAL_MAX : r_diff[VAL_W-1:0];
        st_raddr  = ri_st_ext[ST_AW-1:0];
        out_free  = !r_out_valid || o_out.ready;
        unique case (r_state)
            ST_CLEAR: begin
                bin_we    = 1'b1;
                bin_waddr = r_clr_addr;
                bin_wdata = '0;
            end
            ST_IDLE:    in_ready = 1'b1;
            ST_CMP: begin
                st_we     = store_room;
                div_start = !below_min;
            end
            ST_BUMP_WR: bin_we = 1'b1;
            ST_READ:    bin_raddr = r_ri[BIN_AW-1:0];
            ST_RESP:    out_load = out_free;
            default:    in_ready = 1'b0;
        endcase
    end

    assign accept = i_in.valid && in_ready;

    // ------------------------------------------------------------------
    // Control and run-state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_after_start <= 1'b0;
            r_ref         <= '0;
            r_last        <= '0;
            r_calls       <= '0;
            r_captured    <= '0;
            r_finished    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + BIN_AW'(1);
                if (clr_last) begin
                    r_after_start <= 1'b0;
                end
            end

            if (accept && (t_cmd'(i_in.cmd) == CMD_START)) begin
                r_ref         <= i_in.timestamp;
                r_last        <= '0;
                r_calls       <= '0;
                r_captured    <= '0;
                r_finished    <= 1'b0;
                r_after_start <= 1'b1;
                r_clr_addr    <= '0;
            end

            if ((r_state == ST_REL) && (r_calls != '1)) begin
                r_calls <= r_calls + CALL_W'(1);
            end

            if (r_state == ST_CLASS) begin
                r_last <= r_rel;
                if (!r_rel[REL_W-1] && (r_rel >= {(REL_W-END_W)'(0), r_end_ticks})) begin
                    r_finished <= 1'b1;
                end
            end

            if (st_we) begin
                r_captured <= r_captured + CNT_W'(1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= t_cmd'(i_in.cmd);
            r_ts     <= i_in.timestamp;
            r_ri     <= i_in.read_index;
            r_rd_val <= '0;
        end
        if (r_state == ST_REL) begin
            r_rel <= rel_calc;
        end
        if (r_state == ST_CLASS) begin
            r_diff    <= diff_calc;
            r_bin_idx <= '0;
        end
        if ((r_state == ST_CMP) && below_min) begin
            r_bin_idx <= BIN_AW'(1);
        end
        if (r_state == ST_CLAMP) begin
            r_bin_idx <= bin_sel;
        end
        if (r_state == ST_READ) begin
            r_rd_ok <= (r_cmd == CMD_READ_BIN) ? bin_rd_ok : st_rd_ok;
        end
        if (r_state == ST_READ_DATA) begin
            if (!r_rd_ok) begin
                r_rd_val <= '0;
            end else if (r_cmd == CMD_READ_BIN) begin
                r_rd_val <= {(VAL_W-BIN_CNT_W)'(0), bin_rdata};
            end else begin
                r_rd_val <= st_rdata;
            end
        end
        if (out_load) begin
            r_out_done     <= r_finished;
            r_out_calls    <= r_calls;
            r_out_captured <= cap_ext[CNT_OUT_W-1:0];
            r_out_value    <= r_rd_val;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.done_res       = r_out_done;
    assign o_out.call_total     = r_out_calls;
    assign o_out.captured_total = r_out_captured;
    assign o_out.read_value     = r_out_value;

    // ------------------------------------------------------------------
    // Memories and the divider.
    // ------------------------------------------------------------------
    tdh_ram #(
        .WIDTH (BIN_CNT_W),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    tdh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    tdh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

`ifndef ASSERT_OFF
    // An accepted item always moves the sequencer out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    // The divider is only started when it is free.
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // While waiting on the divider, it is either working or just finished.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");

    // The fill count never passes the store depth.
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_captured <= CNT_W'(STORE_DEPTH))
        else $error("sample store fill count overflow");
`endif

endmodule

[hw/rtl/tdh_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module tdh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/tdh_div.sv]
// Iterative unsigned divider, 64-bit dividend by 32-bit divisor, two bits per cycle.
module tdh_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tdh_pkg::REL_W-1:0]  i_num,
    input  logic [tdh_pkg::BSZ_W-1:0]  i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [tdh_pkg::REL_W-1:0]  o_quot
);
    import tdh_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [REL_W-1:0]     r_qn;
    logic [BSZ_W-1:0]     r_rem;
    logic [BSZ_W-1:0]     r_den;

    logic [BSZ_W:0]   sh1;
    logic [BSZ_W:0]   sh2;
    logic             ge1;
    logic             ge2;
    logic [BSZ_W-1:0] rem1;
    logic [BSZ_W-1:0] rem2;
    logic [REL_W-1:0] qn1;
    logic [REL_W-1:0] qn2;

    // Two restoring steps: the dividend shifts out of the top of r_qn while
    // quotient bits shift in at the bottom.
    always_comb begin
        sh1  = {r_rem, r_qn[REL_W-1]};
        ge1  = sh1 >= {1'b0, r_den};
        rem1 = ge1 ? BSZ_W'(sh1 - {1'b0, r_den}) : sh1[BSZ_W-1:0];
        qn1  = {r_qn[REL_W-2:0], ge1};
        sh2  = {rem1, qn1[REL_W-1]};
        ge2  = sh2 >= {1'b0, r_den};
        rem2 = ge2 ? BSZ_W'(sh2 - {1'b0, r_den}) : sh2[BSZ_W-1:0];
        qn2  = {qn1[REL_W-2:0], ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qn  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_qn  <= qn2;
            r_rem <= rem2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_qn;
endmodule
